>>> hw/rtl/psnp_pkg.sv
// Shared types and constants for the prime sieve next-prime block.
`timescale 1ns / 1ps

package psnp_pkg;

  localparam int VAL_W = 16;
  localparam int MAX_VALUES_DEF = 65536;
  localparam logic [VAL_W-1:0] LIMIT_RESET = 16'd10000;

  typedef struct packed {
    logic [VAL_W-1:0] limit;
    logic             rebuild;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             found;
  } res_t;

endpackage

>>> hw/rtl/psnp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module psnp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = psnp_pkg::MAX_VALUES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/psnp_ctrl.sv
// Sequencer that clears and sieves the composite map and scans it for queries.
`timescale 1ns / 1ps

module psnp_ctrl #(
  parameter int MAX_VALUES = psnp_pkg::MAX_VALUES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  psnp_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  input  logic [psnp_pkg::VAL_W-1:0]    start_value,
  output logic                          idle,
  output logic                          res_valid,
  output psnp_pkg::res_t                res,
  input  logic                          res_ready,
  output logic                          ram_we,
  output logic [$clog2(MAX_VALUES)-1:0] ram_waddr,
  output logic                          ram_wdata,
  output logic [$clog2(MAX_VALUES)-1:0] ram_raddr,
  input  logic                          ram_rdata
);

  localparam int AW = $clog2(MAX_VALUES);
  localparam int XW = psnp_pkg::VAL_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SV_CHECK,
    S_SV_TEST,
    S_MARK,
    S_SC_READ,
    S_SC_TEST,
    S_DONE
  } state_t;

  state_t          state;
  logic            built;
  logic [XW-1:0]   x;
  logic [XW-1:0]   v;
  logic [8:0]      p;
  logic [XW-1:0]   sq;
  logic [XW-1:0]   lim;
  logic [XW-1:0]   x_step;
  logic [XW-1:0]   sq_next;

  assign lim     = {1'b0, cfg.limit};
  assign x_step  = x + XW'(p);
  assign sq_next = sq + XW'({p, 1'b1});

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    ram_we    = (state == S_CLEAR) || (state == S_MARK);
    ram_waddr = AW'(x);
    ram_wdata = (state == S_CLEAR) ? (x < XW'(2)) : 1'b1;
    ram_raddr = (state == S_SV_CHECK) ? AW'(p) : AW'(v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      built <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            v <= {1'b0, start_value};
            x <= '0;
            state <= built ? S_SC_READ : S_CLEAR;
          end
        end
        S_CLEAR: begin
          x <= x + XW'(1);
          if (x == lim) begin
            p <= 9'd2;
            sq <= XW'(4);
            state <= S_SV_CHECK;
          end
        end
        S_SV_CHECK: begin
          if (sq > lim) begin
            built <= 1'b1;
            state <= S_SC_READ;
          end else begin
            state <= S_SV_TEST;
          end
        end
        S_SV_TEST: begin
          if (ram_rdata) begin
            p <= p + 9'd1;
            sq <= sq_next;
            state <= S_SV_CHECK;
          end else begin
            x <= sq;
            state <= S_MARK;
          end
        end
        S_MARK: begin
          if (x_step > lim) begin
            p <= p + 9'd1;
            sq <= sq_next;
            state <= S_SV_CHECK;
          end else begin
            x <= x_step;
          end
        end
        S_SC_READ: begin
          if (v > lim) begin
            res.found <= 1'b0;
            res.value <= '0;
            state <= S_DONE;
          end else begin
            state <= S_SC_TEST;
          end
        end
        S_SC_TEST: begin
          if (!ram_rdata) begin
            res.found <= 1'b1;
            res.value <= v[psnp_pkg::VAL_W-1:0];
            state <= S_DONE;
          end else begin
            v <= v + XW'(1);
            state <= S_SC_READ;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg.rebuild) begin
        built <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/prime_sieve_next_prime.sv
// Top level of the prime sieve next-prime block: limit register, map RAM and output register.
// The first query after reset or a limit write clears entries 0..limit, then sieves each p
// with p*p <= limit: if p is unmarked, it marks multiples of p from p*p up to limit. A query
// reads entries one by one from start_value through the one read port of the map RAM and its
// registered read until one is unmarked (found) or past limit (not found); in_stall is high
// until the result moves to the output. Reset clears out_valid, sets limit 10000 and unbuilds.
`timescale 1ns / 1ps

module prime_sieve_next_prime #(
  parameter int MAX_VALUES = psnp_pkg::MAX_VALUES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       write_enable,
  input  logic [psnp_pkg::VAL_W-1:0] write_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [psnp_pkg::VAL_W-1:0] start_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [psnp_pkg::VAL_W-1:0] prime_value,
  output logic                       found
);

  localparam int AW = $clog2(MAX_VALUES);
  localparam logic [31:0] CAP = 32'(MAX_VALUES - 1);

  logic [psnp_pkg::VAL_W-1:0] upper_limit;
  psnp_pkg::cfg_t             cfg;
  psnp_pkg::res_t             res;
  logic                       idle;
  logic                       res_valid;
  logic                       res_ready;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic                       ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic                       ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= psnp_pkg::LIMIT_RESET;
    end else if (write_enable) begin
      upper_limit <= write_data;
    end
  end

  assign cfg.limit   = (32'(upper_limit) < CAP) ? upper_limit : CAP[psnp_pkg::VAL_W-1:0];
  assign cfg.rebuild = write_enable;

  assign in_stall  = !idle;
  assign res_ready = !out_valid || !out_stall;

  psnp_ctrl #(
    .MAX_VALUES(MAX_VALUES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .start_value(start_value),
    .idle       (idle),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  psnp_ram #(
    .WIDTH(1),
    .DEPTH(MAX_VALUES)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid   <= 1'b1;
      prime_value <= res.value;
      found       <= res.found;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
